// File: hdl/psg_frame_sequencer_top_assert.svh
// assertion macros for the frame sequencer checker
`ifndef PSG_FRAME_SEQUENCER_TOP_ASSERT_SVH
`define PSG_FRAME_SEQUENCER_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PSGFS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("psg frame sequencer check failed");

// consequent checked in the cycle after the antecedent
`define PSGFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("psg frame sequencer check failed");

`endif

// File: hdl/psgfs_pkg.sv
package psgfs_pkg;

    // request codes
    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_SWEEP    = 3'd1,
        REQ_LENGTH   = 3'd2,
        REQ_LEN_EN   = 3'd3,
        REQ_ENVELOPE = 3'd4,
        REQ_TRIGGER  = 3'd5,
        REQ_FREQ     = 3'd6
    } req_t;

    localparam int NUM_CHANNELS = 4;
    localparam int CH_SQ0       = 0;
    localparam int CH_WAVE      = 2;

    localparam int RATE_W = 18;
    localparam int FREQ_W = 11;

    localparam logic [RATE_W-1:0] RATE_RESET     = 18'd42060;
    localparam logic [RATE_W:0]   TICK_INCREMENT = 19'd512;

    localparam logic [2:0] ENV_STEP    = 3'd7;
    localparam logic [1:0] SWEEP_PHASE = 2'd2;
    localparam logic [3:0] VOL_MAX     = 4'hF;

    // wave channel volume codes from envelope byte bits 7..5
    localparam logic [2:0] WAVE_CODE_MUTE  = 3'b000;
    localparam logic [2:0] WAVE_CODE_FULL  = 3'b001;
    localparam logic [2:0] WAVE_CODE_HALF  = 3'b010;
    localparam logic [2:0] WAVE_CODE_QUART = 3'b011;
    localparam logic [2:0] WAVE_CODE_3QUAR = 3'b100;

    localparam logic [3:0] WAVE_VOL_MUTE  = 4'd0;
    localparam logic [3:0] WAVE_VOL_QUART = 4'd1;
    localparam logic [3:0] WAVE_VOL_HALF  = 4'd2;
    localparam logic [3:0] WAVE_VOL_3QUAR = 4'd3;
    localparam logic [3:0] WAVE_VOL_FULL  = 4'd4;

    localparam logic [2:0] WAVE_VOL_LIMIT = 3'd4;

endpackage

// File: hdl/psg_frame_sequencer_top.sv
// four-channel sound control sequencer (length, envelope and sweep timing)
//
// input channel s_*: one request per transaction (tick, sweep, length, length
// enable, envelope, trigger or channel 1 frequency write). every transaction
// yields exactly one status transaction on the m_* channel.
// config channel cfg_*: writes the 18-bit sample rate; always ready. write it
// only while no request is in flight.
//
// latency: a request accepted passes through the input register and then the
// result register before its status shows. throughput is one request per
// cycle while m_ready is high: the input register refills while the result
// register drains, and all channel updates are done in one pass between the two.
//
// reset (aresetn low, synchronous) clears all channel state, the step counter
// and the accumulator, and sets the sample rate to 42060.
// when m_ready is low the result holds; the input register still takes one
// more request, then s_ready drops until the result moves.
module psg_frame_sequencer_top (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_req_type,
    input  logic [1:0]                   s_channel,
    input  logic [7:0]                   s_data,
    input  logic [psgfs_pkg::FREQ_W-1:0] s_freq_value,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [3:0]                   m_enable_bits,
    output logic [3:0]                   m_dac_bits,
    output logic [3:0]                   m_vol_ch0,
    output logic [3:0]                   m_vol_ch1,
    output logic [2:0]                   m_vol_ch2,
    output logic [3:0]                   m_vol_ch3,
    output logic [psgfs_pkg::FREQ_W-1:0] m_ch1_frequency,
    output logic                         m_sweep_overflow,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [psgfs_pkg::RATE_W-1:0] cfg_data
);

    localparam int NCH = psgfs_pkg::NUM_CHANNELS;

    // input register
    logic                         in_valid_reg;
    logic [2:0]                   req_reg;
    logic [1:0]                   chan_reg;
    logic [7:0]                   data_reg;
    logic [psgfs_pkg::FREQ_W-1:0] fval_reg;

    // result register
    logic                         out_valid_reg;
    logic [3:0]                   out_enable_reg;
    logic [3:0]                   out_dac_reg;
    logic [3:0]                   out_vol0_reg;
    logic [3:0]                   out_vol1_reg;
    logic [2:0]                   out_vol2_reg;
    logic [3:0]                   out_vol3_reg;
    logic [psgfs_pkg::FREQ_W-1:0] out_freq_reg;
    logic                         out_ovf_reg;

    // configuration
    logic [psgfs_pkg::RATE_W-1:0] sample_rate_reg;

    // sequencer and channel state
    logic [psgfs_pkg::RATE_W-1:0] accum_reg, accum_next;
    logic [2:0]                   step_reg, step_next;
    logic [NCH-1:0]               chan_en_reg, chan_en_next;
    logic [3:0]                   vol_reg [NCH];
    logic [3:0]                   vol_next [NCH];
    logic [3:0]                   vol_init_reg [NCH];
    logic [3:0]                   vol_init_next [NCH];
    logic [7:0]                   len_reg [NCH];
    logic [7:0]                   len_next [NCH];
    logic [7:0]                   len_init_reg [NCH];
    logic [7:0]                   len_init_next [NCH];
    logic [NCH-1:0]               len_en_reg, len_en_next;
    logic [2:0]                   env_cnt_reg [NCH];
    logic [2:0]                   env_cnt_next [NCH];
    logic [2:0]                   env_per_reg [NCH];
    logic [2:0]                   env_per_next [NCH];
    logic [NCH-1:0]               env_up_reg, env_up_next;
    logic [NCH-1:0]               dac_reg, dac_next;
    logic                         swp_down_reg, swp_down_next;
    logic [2:0]                   swp_cnt_reg, swp_cnt_next;
    logic [2:0]                   swp_per_reg, swp_per_next;
    logic [2:0]                   swp_shift_reg, swp_shift_next;
    logic [psgfs_pkg::FREQ_W-1:0] freq_reg, freq_next;

    // per-item scratch
    logic                         advance;
    logic                         fire;
    logic                         overflow;
    logic [psgfs_pkg::RATE_W:0]   rate_sum;
    logic [2:0]                   swp_cnt_dec;
    logic [psgfs_pkg::FREQ_W-1:0] swp_delta;
    logic [psgfs_pkg::FREQ_W:0]   swp_sum;
    logic [3:0]                   wave_vol;
    logic                         wave_hit;

    // handshake: result register drains, input register refills behind it
    assign advance   = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // wave channel volume decode
    always_comb begin
        wave_hit = 1'b1;
        case (data_reg[7:5])
            psgfs_pkg::WAVE_CODE_MUTE:  wave_vol = psgfs_pkg::WAVE_VOL_MUTE;
            psgfs_pkg::WAVE_CODE_FULL:  wave_vol = psgfs_pkg::WAVE_VOL_FULL;
            psgfs_pkg::WAVE_CODE_HALF:  wave_vol = psgfs_pkg::WAVE_VOL_HALF;
            psgfs_pkg::WAVE_CODE_QUART: wave_vol = psgfs_pkg::WAVE_VOL_QUART;
            psgfs_pkg::WAVE_CODE_3QUAR: wave_vol = psgfs_pkg::WAVE_VOL_3QUAR;
            default: begin
                wave_vol = psgfs_pkg::WAVE_VOL_MUTE;
                wave_hit = 1'b0;
            end
        endcase
    end

    // state update for the item in the input register
    always_comb begin
        accum_next     = accum_reg;
        step_next      = step_reg;
        chan_en_next   = chan_en_reg;
        vol_next       = vol_reg;
        vol_init_next  = vol_init_reg;
        len_next       = len_reg;
        len_init_next  = len_init_reg;
        len_en_next    = len_en_reg;
        env_cnt_next   = env_cnt_reg;
        env_per_next   = env_per_reg;
        env_up_next    = env_up_reg;
        dac_next       = dac_reg;
        swp_down_next  = swp_down_reg;
        swp_cnt_next   = swp_cnt_reg;
        swp_per_next   = swp_per_reg;
        swp_shift_next = swp_shift_reg;
        freq_next      = freq_reg;
        overflow       = 1'b0;
        rate_sum       = {1'b0, accum_reg} + psgfs_pkg::TICK_INCREMENT;
        swp_cnt_dec    = swp_cnt_reg - 3'd1;
        swp_delta      = freq_reg >> swp_shift_reg;
        swp_sum        = swp_down_reg ? ({1'b0, freq_reg} - {1'b0, swp_delta})
                                      : ({1'b0, freq_reg} + {1'b0, swp_delta});

        if (fire) begin
            case (req_reg)
                psgfs_pkg::REQ_TICK: begin
                    if (rate_sum >= {1'b0, sample_rate_reg}) begin
                        rate_sum  = rate_sum - {1'b0, sample_rate_reg};
                        step_next = step_reg + 3'd1;

                        // length counters on even steps
                        if (!step_next[0]) begin
                            for (int c = 0; c < NCH; c++) begin
                                if (len_reg[c] != 8'd0) begin
                                    len_next[c] = len_reg[c] - 8'd1;
                                    if (len_reg[c] == 8'd1 && len_en_reg[c]) begin
                                        chan_en_next[c] = 1'b0;
                                    end
                                end
                            end
                        end

                        // envelopes on the last step, wave channel excluded
                        if (step_next == psgfs_pkg::ENV_STEP) begin
                            for (int c = 0; c < NCH; c++) begin
                                if (c != psgfs_pkg::CH_WAVE && env_cnt_reg[c] != 3'd0) begin
                                    env_cnt_next[c] = env_cnt_reg[c] - 3'd1;
                                    if (env_cnt_reg[c] == 3'd1) begin
                                        if (vol_reg[c] != 4'd0 && !env_up_reg[c]) begin
                                            vol_next[c]     = vol_reg[c] - 4'd1;
                                            env_cnt_next[c] = env_per_reg[c];
                                        end else if (vol_reg[c] != psgfs_pkg::VOL_MAX
                                                     && env_up_reg[c]) begin
                                            vol_next[c]     = vol_reg[c] + 4'd1;
                                            env_cnt_next[c] = env_per_reg[c];
                                        end
                                    end
                                end
                            end
                        end

                        // frequency sweep on steps 2 and 6
                        if (step_next[1:0] == psgfs_pkg::SWEEP_PHASE
                            && swp_per_reg != 3'd0 && swp_shift_reg != 3'd0) begin
                            swp_cnt_next = swp_cnt_dec;
                            if (swp_cnt_dec == 3'd0) begin
                                if (swp_sum[psgfs_pkg::FREQ_W]) begin
                                    chan_en_next[psgfs_pkg::CH_SQ0] = 1'b0;
                                    env_cnt_next[psgfs_pkg::CH_SQ0] = 3'd0;
                                    vol_next[psgfs_pkg::CH_SQ0]     = 4'd0;
                                    overflow                        = 1'b1;
                                end else begin
                                    freq_next = swp_sum[psgfs_pkg::FREQ_W-1:0];
                                end
                                swp_cnt_next = swp_per_reg;
                            end
                        end
                    end
                    accum_next = rate_sum[psgfs_pkg::RATE_W-1:0];
                end
                psgfs_pkg::REQ_SWEEP: begin
                    swp_down_next  = data_reg[3];
                    swp_per_next   = data_reg[6:4];
                    swp_cnt_next   = data_reg[6:4];
                    swp_shift_next = data_reg[2:0];
                end
                psgfs_pkg::REQ_LENGTH: begin
                    len_next[chan_reg]      = data_reg;
                    len_init_next[chan_reg] = data_reg;
                end
                psgfs_pkg::REQ_LEN_EN: begin
                    len_en_next[chan_reg] = data_reg[0];
                end
                psgfs_pkg::REQ_ENVELOPE: begin
                    if (chan_reg == 2'(psgfs_pkg::CH_WAVE)) begin
                        if (wave_hit) begin
                            vol_next[chan_reg]      = wave_vol;
                            vol_init_next[chan_reg] = wave_vol;
                        end
                    end else begin
                        dac_next[chan_reg]      = (data_reg[7:3] != 5'd0);
                        vol_next[chan_reg]      = data_reg[7:4];
                        vol_init_next[chan_reg] = data_reg[7:4];
                        env_up_next[chan_reg]   = data_reg[3];
                        env_cnt_next[chan_reg]  = data_reg[2:0];
                        env_per_next[chan_reg]  = data_reg[2:0];
                    end
                end
                psgfs_pkg::REQ_TRIGGER: begin
                    chan_en_next[chan_reg] = 1'b1;
                    vol_next[chan_reg]     = vol_init_reg[chan_reg];
                    len_next[chan_reg]     = len_init_reg[chan_reg];
                    if (chan_reg != 2'(psgfs_pkg::CH_WAVE)) begin
                        env_cnt_next[chan_reg] = env_per_reg[chan_reg];
                    end
                end
                psgfs_pkg::REQ_FREQ: begin
                    freq_next = fval_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_rate_reg <= psgfs_pkg::RATE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            sample_rate_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg  <= s_req_type;
            chan_reg <= s_channel;
            data_reg <= s_data;
            fval_reg <= s_freq_value;
        end
    end

    // sequencer and channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg     <= '0;
            step_reg      <= '0;
            chan_en_reg   <= '0;
            len_en_reg    <= '0;
            env_up_reg    <= '0;
            dac_reg       <= '0;
            swp_down_reg  <= 1'b0;
            swp_cnt_reg   <= '0;
            swp_per_reg   <= '0;
            swp_shift_reg <= '0;
            freq_reg      <= '0;
            for (int c = 0; c < NCH; c++) begin
                vol_reg[c]      <= '0;
                vol_init_reg[c] <= '0;
                len_reg[c]      <= '0;
                len_init_reg[c] <= '0;
                env_cnt_reg[c]  <= '0;
                env_per_reg[c]  <= '0;
            end
        end else begin
            accum_reg     <= accum_next;
            step_reg      <= step_next;
            chan_en_reg   <= chan_en_next;
            len_en_reg    <= len_en_next;
            env_up_reg    <= env_up_next;
            dac_reg       <= dac_next;
            swp_down_reg  <= swp_down_next;
            swp_cnt_reg   <= swp_cnt_next;
            swp_per_reg   <= swp_per_next;
            swp_shift_reg <= swp_shift_next;
            freq_reg      <= freq_next;
            vol_reg       <= vol_next;
            vol_init_reg  <= vol_init_next;
            len_reg       <= len_next;
            len_init_reg  <= len_init_next;
            env_cnt_reg   <= env_cnt_next;
            env_per_reg   <= env_per_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_enable_reg <= chan_en_next;
            out_dac_reg    <= dac_next;
            out_vol0_reg   <= vol_next[0];
            out_vol1_reg   <= vol_next[1];
            out_vol2_reg   <= vol_next[2][2:0];
            out_vol3_reg   <= vol_next[3];
            out_freq_reg   <= freq_next;
            out_ovf_reg    <= overflow;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_enable_bits    = out_enable_reg;
    assign m_dac_bits       = out_dac_reg;
    assign m_vol_ch0        = out_vol0_reg;
    assign m_vol_ch1        = out_vol1_reg;
    assign m_vol_ch2        = out_vol2_reg;
    assign m_vol_ch3        = out_vol3_reg;
    assign m_ch1_frequency  = out_freq_reg;
    assign m_sweep_overflow = out_ovf_reg;

endmodule

// File: hdl/psgfs_checker.sv
`include "psg_frame_sequencer_top_assert.svh"

module psgfs_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [3:0]                   m_enable_bits,
    input logic [3:0]                   m_dac_bits,
    input logic [3:0]                   m_vol_ch0,
    input logic [3:0]                   m_vol_ch1,
    input logic [2:0]                   m_vol_ch2,
    input logic [3:0]                   m_vol_ch3,
    input logic [psgfs_pkg::FREQ_W-1:0] m_ch1_frequency,
    input logic                         m_sweep_overflow
);

    logic [34:0] m_payload;

    assign m_payload = {m_enable_bits, m_dac_bits, m_vol_ch0, m_vol_ch1, m_vol_ch2,
                        m_vol_ch3, m_ch1_frequency, m_sweep_overflow};

    // a stalled result holds its value
    `PSGFS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))

    // a free output side never blocks the input side
    `PSGFS_ASSERT_NOW(a_in_ready, aclk, aresetn, m_ready, s_ready)

    // a sweep overflow shuts channel 1 off and mutes it
    `PSGFS_ASSERT_NOW(a_ovf_mute, aclk, aresetn, m_valid && m_sweep_overflow, !m_enable_bits[0] && (m_vol_ch0 == 4'd0))

    // wave volume stays within its five levels
    `PSGFS_ASSERT_NOW(a_wave_vol, aclk, aresetn, m_valid, m_vol_ch2 <= psgfs_pkg::WAVE_VOL_LIMIT)

    // the wave channel converter flag is never set by envelope writes
    `PSGFS_ASSERT_NOW(a_wave_dac, aclk, aresetn, m_valid, !m_dac_bits[2])

endmodule

bind psg_frame_sequencer_top psgfs_checker u_psgfs_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_enable_bits    (m_enable_bits),
    .m_dac_bits       (m_dac_bits),
    .m_vol_ch0        (m_vol_ch0),
    .m_vol_ch1        (m_vol_ch1),
    .m_vol_ch2        (m_vol_ch2),
    .m_vol_ch3        (m_vol_ch3),
    .m_ch1_frequency  (m_ch1_frequency),
    .m_sweep_overflow (m_sweep_overflow)
);
